// File: sv/msps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types and constants of the multi-channel servo pulse sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

  localparam logic [1:0]  REQ_TICK = 2'd0;
  localparam logic [1:0]  REQ_SET  = 2'd1;
  localparam logic [1:0]  REQ_STOP = 2'd2;

  localparam logic        CFG_CHANNEL_COUNT = 1'b0;
  localparam logic        CFG_PIN_MAP       = 1'b1;

  localparam logic [15:0] RELOAD_20MS  = 16'h63C0;
  localparam logic [15:0] RELOAD_600US = 16'hFB50;
  localparam logic [15:0] RELOAD_10US  = 16'hFFEC;
  localparam logic [7:0]  LAST_STEP    = 8'd179;
  localparam logic [7:0]  STEP_RESET   = 8'hFF;
  localparam logic [7:0]  ANGLE_RESET  = 8'd90;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_PULSE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN,
    ST_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic finish;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: sv/msps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_ctrl
// Sequencer controller: accepts a transaction, executes it, walks the channel
// compare loop on stepping ticks and hands the result to the output register.
// ----------------------------------------------------------------------------
module msps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  msps_pkg::dp_sts_t sts_i,
  output msps_pkg::dp_cmd_t cmd_o
);
  import msps_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = sts_i.need_scan ? ST_SCAN : ST_PUSH;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
      end
      ST_PUSH: begin
        cmd_o.push = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: sv/msps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_dp
// Sequencer datapath: configuration, run and phase state, step counter,
// pin level, port and reload registers, channel angles and output register.
// ----------------------------------------------------------------------------
module msps_dp #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [23:0]       cfg_data_i,
  input  logic [1:0]        req_type_i,
  input  logic [2:0]        servo_index_i,
  input  logic [7:0]        angle_i,
  input  msps_pkg::dp_cmd_t cmd_i,
  output msps_pkg::dp_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        port_pins_o,
  output logic [15:0]       timer_reload_o,
  output logic              running_o,
  output logic [1:0]        phase_o
);
  import msps_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [3:0]      cnt_q;
  logic [23:0]     pin_map_q;
  logic [1:0]      req_q, req_d;
  logic [2:0]      idx_q, idx_d;
  logic [7:0]      ang_q, ang_d;
  logic            run_q, run_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      step_q, step_d;
  logic [7:0]      level_q, level_d;
  logic [7:0]      port_q, port_d;
  logic [15:0]     reload_q, reload_d;
  logic [7:0]      angle_q [NUM_CHANNELS];
  logic [7:0]      angle_d [NUM_CHANNELS];
  logic [CH_W-1:0] ch_q, ch_d;
  logic            out_valid_q;
  logic [7:0]      out_port_q;
  logic [15:0]     out_reload_q;
  logic            out_run_q;
  logic [1:0]      out_phase_q;

  logic [3:0]      n_act;
  logic [7:0]      mask;
  logic [7:0]      chan_bit;
  logic [7:0]      step_inc;
  logic            ch_active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pin_map_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHANNEL_COUNT: cnt_q     <= cfg_data_i[3:0];
        CFG_PIN_MAP:       pin_map_q <= cfg_data_i;
        default:           cnt_q     <= cnt_q;
      endcase
    end
  end

  assign n_act     = (cnt_q > 4'(NUM_CHANNELS)) ? 4'(NUM_CHANNELS) : cnt_q;
  assign chan_bit  = 8'd1 << pin_map_q[5'(ch_q) * 5'd3 +: 3];
  assign ch_active = 4'(ch_q) < n_act;
  assign step_inc  = step_q + 8'd1;

  always_comb begin
    mask = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (4'(i) < n_act) mask = mask | (8'd1 << pin_map_q[3*i +: 3]);
    end
  end

  always_comb begin
    req_d    = req_q;
    idx_d    = idx_q;
    ang_d    = ang_q;
    run_d    = run_q;
    phase_d  = phase_q;
    step_d   = step_q;
    level_d  = level_q;
    port_d   = port_q;
    reload_d = reload_q;
    angle_d  = angle_q;
    ch_d     = ch_q;
    if (cmd_i.capture) begin
      req_d = req_type_i;
      idx_d = servo_index_i;
      ang_d = angle_i;
      ch_d  = '0;
    end
    if (cmd_i.exec) begin
      unique case (req_q)
        REQ_SET: begin
          if (4'(idx_q) < 4'(NUM_CHANNELS)) angle_d[idx_q[CH_W-1:0]] = ang_q;
          run_d = 1'b1;
        end
        REQ_STOP: begin
          reload_d = RELOAD_20MS;
          phase_d  = PH_WAIT;
          run_d    = 1'b0;
        end
        REQ_TICK: begin
          if (run_q) begin
            if (phase_q == PH_WAIT) begin
              port_d   = mask;
              reload_d = RELOAD_600US;
              phase_d  = PH_HIGH;
            end else begin
              if (phase_q == PH_HIGH) reload_d = RELOAD_10US;
              phase_d = PH_PULSE;
              step_d  = step_inc;
              if (step_inc == 8'd0) begin
                level_d = mask;
                port_d  = mask;
              end else begin
                port_d  = level_q;
              end
            end
          end
        end
        default: begin
          run_d = run_q;
        end
      endcase
    end
    if (cmd_i.scan) begin
      if (ch_active && (angle_q[ch_q] == step_q)) level_d = level_q & ~chan_bit;
      ch_d = ch_q + CH_W'(1);
    end
    if (cmd_i.finish && (step_q == LAST_STEP)) begin
      reload_d = RELOAD_20MS;
      phase_d  = PH_WAIT;
      step_d   = STEP_RESET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      phase_q  <= PH_WAIT;
      step_q   <= STEP_RESET;
      level_q  <= '0;
      port_q   <= '0;
      reload_q <= RELOAD_20MS;
      ch_q     <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) angle_q[i] <= ANGLE_RESET;
    end else begin
      run_q    <= run_d;
      phase_q  <= phase_d;
      step_q   <= step_d;
      level_q  <= level_d;
      port_q   <= port_d;
      reload_q <= reload_d;
      ch_q     <= ch_d;
      angle_q  <= angle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    idx_q <= idx_d;
    ang_q <= ang_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_port_q   <= port_q;
      out_reload_q <= reload_q;
      out_run_q    <= run_q;
      out_phase_q  <= phase_q;
    end
  end

  assign sts_o.need_scan = (req_q == REQ_TICK) && run_q && (phase_q != PH_WAIT);
  assign sts_o.scan_last = ch_q == CH_W'(NUM_CHANNELS - 1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign port_pins_o    = out_port_q;
  assign timer_reload_o = out_reload_q;
  assign running_o      = out_run_q;
  assign phase_o        = out_phase_q;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q <= LAST_STEP) || (step_q == STEP_RESET))
    else $error("step counter out of range");
  a_pulse_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PULSE) |-> (reload_q == RELOAD_10US))
    else $error("pulse phase without 10 us reload");
  a_high_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HIGH) |-> (reload_q == RELOAD_600US))
    else $error("lead-in phase without 600 us reload");
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (req_q == REQ_STOP)) |=> (!run_q && (phase_q == PH_WAIT)))
    else $error("stop did not halt the sequencer");
`endif

endmodule

// File: sv/multi_servo_pwm_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_servo_pwm_sequencer
// Servo pulse sequencer for up to NUM_CHANNELS channels on one 8-bit port.
// ----------------------------------------------------------------------------
// Each input transaction (tick, set angle and run, stop) yields exactly one
// output transaction carrying the port level, timer reload, run flag and
// phase. A set, a stop, an idle tick or a tick in the wait phase passes
// through accept, execute and hand-off; a tick in the lead-in or stepping
// phase also runs the channel compare loop and a finish step before hand-off,
// visiting one channel angle per cycle through a single comparator. The next
// transaction is accepted while a finished result still waits in the output
// register; hand-off waits only when that register is still full.
module multi_servo_pwm_sequencer #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // servo_index[2:0], angle[10:3], zero pad
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // port_pins[7:0], timer_reload[23:8],
                                      // running[24], phase[26:25], zero pad
);
  import msps_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [7:0]  port_pins;
  logic [15:0] timer_reload;
  logic        running;
  logic [1:0]  phase;

  msps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msps_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (s_axis_tuser),
    .servo_index_i  (s_axis_tdata[2:0]),
    .angle_i        (s_axis_tdata[10:3]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .port_pins_o    (port_pins),
    .timer_reload_o (timer_reload),
    .running_o      (running),
    .phase_o        (phase)
  );

  assign m_axis_tdata = {5'b0, phase, running, timer_reload, port_pins};

endmodule

// File: dv/tb_multi_servo_pwm_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_servo_pwm_sequencer
// Self-checking bench for the servo pulse sequencer: a queue-fed stream
// driver issues ticks, angle writes, stops and unused requests under several
// channel count and pin map settings, a built-in predictor computes each
// status transaction, and a monitor compares every field as it arrives.
// ----------------------------------------------------------------------------
module tb_multi_servo_pwm_sequencer;
  import msps_pkg::*;

  localparam int          NUM_CH     = 8;
  localparam int          CYCLE_CAP  = 200000;
  localparam int          LONG_HOLD  = 400;
  localparam int          HOLD_AT    = 300;
  localparam int          SETTLE     = NUM_CH + 8;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam logic [23:0] IDENT_MAP  = 24'hFAC688;

  typedef struct packed {
    logic [1:0] req;
    logic [2:0] idx;
    logic [7:0] ang;
  } servo_req_t;

  typedef struct packed {
    logic [7:0]  pins;
    logic [15:0] reload;
    logic        running;
    phase_e      phase;
  } seq_status_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_idx_i      = 1'b0;
  logic [23:0] cfg_data_i     = '0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata   = '0;  // servo_index[2:0], angle[10:3], zero pad
  logic [1:0]  s_axis_tuser   = '0;  // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [31:0] m_axis_tdata;         // port_pins[7:0], timer_reload[23:8],
                                     // running[24], phase[26:25], zero pad

  servo_req_t  req_pending[$];
  seq_status_t status_expect[$];
  int          mismatches = 0;
  int          cycles = 0;

  // predictor state
  logic [3:0]  cfg_count;
  logic [23:0] cfg_map;
  logic        seq_run;
  phase_e      seq_phase;
  logic [7:0]  step_cnt;
  logic [7:0]  level_bits;
  logic [7:0]  port_bits;
  logic [15:0] reload_val;
  logic [7:0]  angle_tab [NUM_CH];

  // driver and monitor state
  servo_req_t  cur_req;
  int          gap_left = 0;
  bit          tx_calm = 1'b0;
  int          hold_left = 0;
  bit          rx_calm = 1'b0;
  int          results_seen = 0;

  multi_servo_pwm_sequencer #(
    .NUM_CHANNELS(NUM_CH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic void reset_model();
    cfg_count  = '0;
    cfg_map    = '0;
    seq_run    = 1'b0;
    seq_phase  = PH_WAIT;
    step_cnt   = STEP_RESET;
    level_bits = '0;
    port_bits  = '0;
    reload_val = RELOAD_20MS;
    for (int i = 0; i < NUM_CH; i++) angle_tab[i] = ANGLE_RESET;
  endfunction

  function automatic int live_channels();
    return (cfg_count > NUM_CH) ? NUM_CH : int'(cfg_count);
  endfunction

  function automatic logic [7:0] enabled_bits();
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < live_channels(); i++) m[cfg_map[3*i +: 3]] = 1'b1;
    return m;
  endfunction

  function automatic void advance_tick();
    if (!seq_run) return;
    if (seq_phase == PH_WAIT) begin
      port_bits  = enabled_bits();
      reload_val = RELOAD_600US;
      seq_phase  = PH_HIGH;
      return;
    end
    if (seq_phase == PH_HIGH) begin
      reload_val = RELOAD_10US;
      seq_phase  = PH_PULSE;
    end
    step_cnt = step_cnt + 8'd1;
    if (step_cnt == 8'd0) level_bits = enabled_bits();
    port_bits = level_bits;
    for (int i = 0; i < live_channels(); i++) begin
      if (angle_tab[i] == step_cnt) level_bits[cfg_map[3*i +: 3]] = 1'b0;
    end
    if (step_cnt == LAST_STEP) begin
      reload_val = RELOAD_20MS;
      seq_phase  = PH_WAIT;
      step_cnt   = STEP_RESET;
    end
  endfunction

  function automatic seq_status_t apply_request(servo_req_t r);
    seq_status_t s;
    case (r.req)
      REQ_TICK: advance_tick();
      REQ_SET: begin
        if (r.idx < NUM_CH) angle_tab[r.idx] = r.ang;
        seq_run = 1'b1;
      end
      REQ_STOP: begin
        reload_val = RELOAD_20MS;
        seq_phase  = PH_WAIT;
        seq_run    = 1'b0;
      end
      default: ;
    endcase
    s.pins    = port_bits;
    s.reload  = reload_val;
    s.running = seq_run;
    s.phase   = seq_phase;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch: %s got %0h want %0h (result %0d)", what, got, want,
             results_seen);
    mismatches++;
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CFG_CHANNEL_COUNT) cfg_count = val[3:0];
    else cfg_map = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_req(input logic [1:0] req, input logic [2:0] idx,
                          input logic [7:0] ang);
    servo_req_t r;
    r.req = req;
    r.idx = idx;
    r.ang = ang;
    req_pending.push_back(r);
  endtask

  function automatic logic [7:0] draw_angle();
    return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 179))
                                       : 8'($urandom_range(0, 255));
  endfunction

  // hold until every transaction is through and the block has gone quiet
  task automatic drain();
    while (req_pending.size() != 0 || s_axis_tvalid || status_expect.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic fill_phase(input int budget);
    int left;
    int seg;
    int roll;
    left = budget;
    while (left > 0) begin
      push_req(REQ_SET, 3'($urandom_range(0, 7)), draw_angle());
      left--;
      seg = $urandom_range(60, 420);
      for (int k = 0; k < seg && left > 0; k++) begin
        roll = $urandom_range(0, 399);
        if (roll < 374)
          push_req(REQ_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        else if (roll < 392)
          push_req(REQ_SET, 3'($urandom_range(0, 7)), draw_angle());
        else if (roll < 398)
          push_req(REQ_UNUSED, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        else
          push_req(REQ_STOP, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        left--;
      end
      if ($urandom_range(0, 1) != 0) begin
        push_req(REQ_STOP, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        left--;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) status_expect.push_back(apply_request(cur_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (req_pending.size() > 0) begin
          cur_req = req_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b00000, cur_req.ang, cur_req.idx};
          s_axis_tuser  <= cur_req.req;
          if ($urandom_range(0, 59) == 0) tx_calm = !tx_calm;
          gap_left = tx_calm ? 0 : $urandom_range(0, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    seq_status_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (status_expect.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 0);
        end else begin
          want = status_expect.pop_front();
          if (m_axis_tdata[7:0] !== want.pins)
            report_mismatch("port_pins", m_axis_tdata[7:0], want.pins);
          if (m_axis_tdata[23:8] !== want.reload)
            report_mismatch("timer_reload", m_axis_tdata[23:8], want.reload);
          if (m_axis_tdata[24] !== want.running)
            report_mismatch("running", m_axis_tdata[24], want.running);
          if (m_axis_tdata[26:25] !== want.phase)
            report_mismatch("phase", m_axis_tdata[26:25], want.phase);
        end
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        hold_left = rx_calm ? 0 : $urandom_range(0, 3);
        if (results_seen == HOLD_AT) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int waited;
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_CHANNEL_COUNT, 24'd8);
    write_reg(CFG_PIN_MAP, IDENT_MAP);
    push_req(REQ_TICK, 3'd0, 8'd0);
    push_req(REQ_UNUSED, 3'd7, 8'd255);
    push_req(REQ_STOP, 3'd0, 8'd0);
    push_req(REQ_SET, 3'd0, 8'd0);
    push_req(REQ_SET, 3'd7, 8'd255);
    push_req(REQ_SET, 3'd3, LAST_STEP);
    push_req(REQ_SET, 3'd1, 8'd180);
    push_req(REQ_TICK, 3'd7, 8'd255);
    push_req(REQ_TICK, 3'd0, 8'd0);
    push_req(REQ_TICK, 3'd2, 8'h55);
    push_req(REQ_UNUSED, 3'd5, 8'hAA);
    push_req(REQ_TICK, 3'd0, 8'd0);
    push_req(REQ_STOP, 3'd7, 8'd255);
    push_req(REQ_TICK, 3'd0, 8'd0);
    push_req(REQ_SET, 3'd2, 8'd1);
    push_req(REQ_TICK, 3'd0, 8'd0);
    push_req(REQ_TICK, 3'd0, 8'd0);
    push_req(REQ_TICK, 3'd0, 8'd0);
    push_req(REQ_SET, 3'd6, 8'd2);
    push_req(REQ_TICK, 3'd0, 8'd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_CHANNEL_COUNT, 24'd0);
          write_reg(CFG_PIN_MAP, 24'd0);
        end
        1: begin
          write_reg(CFG_CHANNEL_COUNT, 24'd15);
          write_reg(CFG_PIN_MAP, 24'hFFFFFF);
        end
        2: begin
          write_reg(CFG_CHANNEL_COUNT, 24'd8);
          write_reg(CFG_PIN_MAP, IDENT_MAP);
        end
        3: begin
          write_reg(CFG_CHANNEL_COUNT, 24'd1);
          write_reg(CFG_PIN_MAP, 24'($urandom));
        end
        4: begin
          write_reg(CFG_CHANNEL_COUNT, 24'($urandom_range(0, 15)));
          write_reg(CFG_PIN_MAP, 24'($urandom));
        end
        default: begin
          write_reg(CFG_CHANNEL_COUNT, 24'd8);
          write_reg(CFG_PIN_MAP, 24'($urandom));
        end
      endcase
      fill_phase(208);
      drain();
    end

    waited = 0;
    while (status_expect.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (status_expect.size() != 0)
      report_mismatch("expectation left over", status_expect.size(), 0);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
